FILE: design/rlpf_pkg.sv
// Shared types and constants for the RGB LED plane PWM framer.
// No dependencies; imported by the controller, datapath and top level.
package rlpf_pkg;

   localparam int LEVEL_W    = 8;
   localparam int FRAME_W    = 16;
   localparam int PLANE_W    = 2;
   localparam int STEP_OUT_W = 6;
   localparam int OPCODE_W   = 3;
   localparam int INDEX_W    = 8;
   localparam int COLOUR_W   = 24;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

   localparam logic [OPCODE_W-1:0] OP_TICK       = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_SET_COLOUR = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_SET_MODE   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_SET_STATE  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_SET_USER   = 3'd4;

   localparam logic [PLANE_W-1:0] PLANE_RED   = 2'd0;
   localparam logic [PLANE_W-1:0] PLANE_GREEN = 2'd1;
   localparam logic [PLANE_W-1:0] PLANE_BLUE  = 2'd2;

   typedef enum logic [2:0] {
      PH_RED   = 3'b001,
      PH_GREEN = 3'b010,
      PH_BLUE  = 3'b100
   } phase_type;

   typedef struct packed {
      logic                 wr_colour;
      logic                 wr_mode;
      logic                 wr_state;
      logic                 wr_user;
      logic                 tick;
      logic                 latch;
      logic [PLANE_W-1:0]   plane;
   } cmd_type;

endpackage

FILE: design/rlpf_ctrl.sv
// Controller: decodes command beats and sequences the colour plane phase.
// Depends on rlpf_pkg; drives the datapath through a cmd_type bundle.
module rlpf_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rlpf_pkg::OPCODE_W-1:0]  req_opcode,
   output rlpf_pkg::cmd_type              cmd
);
   import rlpf_pkg::*;

   phase_type phase_ff, phase_in;
   logic      tick_req;

   always_comb begin
      cmd      = '0;
      tick_req = 1'b0;
      if (start) begin
         unique case (req_opcode)
            OP_TICK:       tick_req      = 1'b1;
            OP_SET_COLOUR: cmd.wr_colour = 1'b1;
            OP_SET_MODE:   cmd.wr_mode   = 1'b1;
            OP_SET_STATE:  cmd.wr_state  = 1'b1;
            OP_SET_USER:   cmd.wr_user   = 1'b1;
            default:       ;
         endcase
      end
      cmd.tick = tick_req;
      unique case (phase_ff)
         PH_RED:   cmd.plane = PLANE_RED;
         PH_GREEN: cmd.plane = PLANE_GREEN;
         PH_BLUE:  cmd.plane = PLANE_BLUE;
         default:  cmd.plane = PLANE_BLUE;
      endcase
      cmd.latch = (phase_ff == PH_BLUE);
   end

   always_comb begin
      phase_in = phase_ff;
      if (tick_req) begin
         unique case (phase_ff)
            PH_RED:   phase_in = PH_GREEN;
            PH_GREEN: phase_in = PH_BLUE;
            PH_BLUE:  phase_in = PH_RED;
            default:  phase_in = PH_RED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RED;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: design/rlpf_datapath.sv
// Datapath: LED table, PWM step counter, per-LED threshold compare, result register.
// Depends on rlpf_pkg; commanded by rlpf_ctrl through a cmd_type bundle.
module rlpf_datapath #(
   parameter int NUM_LEDS  = 12,
   parameter int PWM_STEPS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rlpf_pkg::cmd_type                 cmd,
   input  logic [rlpf_pkg::INDEX_W-1:0]      req_led_index,
   input  logic [rlpf_pkg::COLOUR_W-1:0]     req_colour_value,
   input  logic                              req_flag_value,
   output logic                              rsp_strobe,
   output logic [rlpf_pkg::FRAME_W-1:0]      rsp_frame_bits,
   output logic [rlpf_pkg::PLANE_W-1:0]      rsp_plane,
   output logic                              rsp_latch_pulse,
   output logic [rlpf_pkg::STEP_OUT_W-1:0]   rsp_step_out
);
   import rlpf_pkg::*;

   localparam int STEP_W = $clog2(PWM_STEPS);
   localparam int CMP_W  = (STEP_W + 2 > LEVEL_W) ? STEP_W + 2 : LEVEL_W;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PWM_STEPS - 1);

   logic [LEVEL_W-1:0] red_ff   [NUM_LEDS];
   logic [LEVEL_W-1:0] green_ff [NUM_LEDS];
   logic [LEVEL_W-1:0] blue_ff  [NUM_LEDS];
   logic [LEVEL_W-1:0] red_in   [NUM_LEDS];
   logic [LEVEL_W-1:0] green_in [NUM_LEDS];
   logic [LEVEL_W-1:0] blue_in  [NUM_LEDS];
   logic [NUM_LEDS-1:0] mode_ff, mode_in;
   logic [NUM_LEDS-1:0] dflt_on_ff, dflt_on_in;
   logic [NUM_LEDS-1:0] user_on_ff, user_on_in;
   logic [NUM_LEDS-1:0] sel;
   logic [NUM_LEDS-1:0] lit;
   logic                all_leds;

   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CMP_W-1:0]    limit;
   logic [STEP_W+STEP_OUT_W-1:0] step_wide;

   logic                 strobe_ff;
   logic [FRAME_W-1:0]   frame_ff;
   logic [PLANE_W-1:0]   plane_ff;
   logic                 latch_ff;
   logic [STEP_OUT_W-1:0] step_out_ff;

   assign all_leds = (req_led_index >= INDEX_W'(NUM_LEDS));

   always_comb begin
      for (int i = 0; i < NUM_LEDS; i++) begin
         sel[i]        = all_leds || (req_led_index == INDEX_W'(i));
         red_in[i]     = red_ff[i];
         green_in[i]   = green_ff[i];
         blue_in[i]    = blue_ff[i];
         mode_in[i]    = mode_ff[i];
         dflt_on_in[i] = dflt_on_ff[i];
         user_on_in[i] = user_on_ff[i];
         if (sel[i]) begin
            if (cmd.wr_colour) begin
               red_in[i]   = req_colour_value[23:16];
               green_in[i] = req_colour_value[15:8];
               blue_in[i]  = req_colour_value[7:0];
            end
            if (cmd.wr_mode) begin
               mode_in[i] = req_flag_value;
            end
            if (cmd.wr_state) begin
               if (mode_ff[i]) begin
                  user_on_in[i] = req_flag_value;
               end else begin
                  dflt_on_in[i] = req_flag_value;
               end
            end
            if (cmd.wr_user) begin
               user_on_in[i] = req_flag_value;
            end
         end
      end
   end

   assign limit = CMP_W'({step_ff, 2'b00});

   always_comb begin
      for (int i = 0; i < NUM_LEDS; i++) begin
         logic [LEVEL_W-1:0] lvl;
         logic               on;
         on = mode_ff[i] ? user_on_ff[i] : dflt_on_ff[i];
         case (cmd.plane)
            PLANE_RED:   lvl = red_ff[i];
            PLANE_GREEN: lvl = green_ff[i];
            default:     lvl = blue_ff[i];
         endcase
         lit[i] = on && (CMP_W'(lvl) > limit);
      end
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.tick && cmd.latch) begin
         step_in = (step_ff == STEP_LAST) ? '0 : step_ff + STEP_W'(1);
      end
   end

   assign step_wide = {{STEP_OUT_W{1'b0}}, step_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEDS; i++) begin
            red_ff[i]   <= LEVEL_MAX;
            green_ff[i] <= LEVEL_MAX;
            blue_ff[i]  <= LEVEL_MAX;
         end
         mode_ff    <= '0;
         dflt_on_ff <= '0;
         user_on_ff <= '1;
         step_ff    <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_LEDS; i++) begin
            red_ff[i]   <= red_in[i];
            green_ff[i] <= green_in[i];
            blue_ff[i]  <= blue_in[i];
         end
         mode_ff    <= mode_in;
         dflt_on_ff <= dflt_on_in;
         user_on_ff <= user_on_in;
         step_ff    <= step_in;
         strobe_ff  <= cmd.tick;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick) begin
         frame_ff    <= FRAME_W'({lit, 2'b00});
         plane_ff    <= cmd.plane;
         latch_ff    <= cmd.latch;
         step_out_ff <= step_wide[STEP_OUT_W-1:0];
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_frame_bits  = frame_ff;
   assign rsp_plane       = plane_ff;
   assign rsp_latch_pulse = latch_ff;
   assign rsp_step_out    = step_out_ff;

endmodule

FILE: design/rgb_led_plane_pwm_framer.sv
// RGB LED plane PWM framer, top level: joins rlpf_ctrl and rlpf_datapath.
// A tick beat gives its frame on rsp_strobe in the cycle after acceptance.
// Throughput: one command beat per cycle; busy stays low, every beat is taken at once.
// The set opcodes write the LED table in the accepting cycle and give no result; opcodes 5 to 7 do nothing.
// Synchronous reset: all LEDs white, default mode, default off, user on; red plane, step 0.
// The receiver cannot stall; rsp_strobe marks each frame on the rsp_ ports for exactly one cycle.
module rgb_led_plane_pwm_framer #(
   parameter int NUM_LEDS  = 12,
   parameter int PWM_STEPS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rlpf_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [rlpf_pkg::INDEX_W-1:0]      req_led_index,
   input  logic [rlpf_pkg::COLOUR_W-1:0]     req_colour_value,
   input  logic                              req_flag_value,
   output logic                              rsp_strobe,
   output logic [rlpf_pkg::FRAME_W-1:0]      rsp_frame_bits,
   output logic [rlpf_pkg::PLANE_W-1:0]      rsp_plane,
   output logic                              rsp_latch_pulse,
   output logic [rlpf_pkg::STEP_OUT_W-1:0]   rsp_step_out
);
   import rlpf_pkg::*;

   cmd_type cmd;
   logic    accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   rlpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .req_opcode (req_opcode),
      .cmd        (cmd)
   );

   rlpf_datapath #(
      .NUM_LEDS  (NUM_LEDS),
      .PWM_STEPS (PWM_STEPS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_led_index    (req_led_index),
      .req_colour_value (req_colour_value),
      .req_flag_value   (req_flag_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_frame_bits   (rsp_frame_bits),
      .rsp_plane        (rsp_plane),
      .rsp_latch_pulse  (rsp_latch_pulse),
      .rsp_step_out     (rsp_step_out)
   );

`ifndef SYNTHESIS
   a_tick_gives_beat: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_TICK) |=> rsp_strobe)
      else $error("tick beat gave no result");

   a_beat_from_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept && req_opcode == OP_TICK))
      else $error("result beat without a tick");

   a_latch_on_blue: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_latch_pulse == (rsp_plane == PLANE_BLUE)))
      else $error("latch pulse out of step with blue plane");

   a_frame_low_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_frame_bits[1:0] == 2'b00))
      else $error("frame drives unused low bits");
`endif

endmodule
